>>> rtl/circle_elastic_collision_defines.svh
// Assertion macros for the circle collision block
`ifndef CIRCLE_ELASTIC_COLLISION_DEFINES_SVH
`define CIRCLE_ELASTIC_COLLISION_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CEC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define CEC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cec_pkg.sv
// Shared types, constants and rounding multiply for the circle collision pipeline
package cec_pkg;

	localparam int PW        = 32;             // position word
	localparam int DW        = PW + 1;         // centre distance
	localparam int SQW       = 2 * PW + 3;     // sqrt radicand and work words
	localparam int SQ_STEPS  = DW;             // one root bit per stage
	localparam int NRM_BITS  = 30;             // normal and mass split, Q.30
	localparam int RW        = 42;             // wide signed intermediate
	localparam int MA_W      = 40;             // first operand of smul_rnd
	localparam int MB_W      = 32;             // second operand of smul_rnd
	localparam logic [15:0] RST_RESET = 16'd13107;
	localparam logic [16:0] RST_ONE   = 17'd16384;

	typedef struct packed {
		logic signed [PW-1:0] a_pos_x;
		logic signed [PW-1:0] a_pos_y;
		logic signed [PW-1:0] a_prev_x;
		logic signed [PW-1:0] a_prev_y;
		logic [PW-2:0]        a_radius;
		logic [PW-2:0]        a_mass;
		logic signed [PW-1:0] b_pos_x;
		logic signed [PW-1:0] b_pos_y;
		logic signed [PW-1:0] b_prev_x;
		logic signed [PW-1:0] b_prev_y;
		logic [PW-2:0]        b_radius;
		logic [PW-2:0]        b_mass;
	} pair_t;

	typedef struct packed {
		logic signed [PW-1:0] a_new_x;
		logic signed [PW-1:0] a_new_y;
		logic signed [PW-1:0] a_new_prev_x;
		logic signed [PW-1:0] a_new_prev_y;
		logic signed [PW-1:0] b_new_x;
		logic signed [PW-1:0] b_new_y;
		logic signed [PW-1:0] b_new_prev_x;
		logic signed [PW-1:0] b_new_prev_y;
		logic                 touching;
		logic                 degenerate;
	} result_t;

	// normal magnitudes and mass split out of the divider
	typedef struct packed {
		logic [NRM_BITS:0] nx_mag;
		logic [NRM_BITS:0] ny_mag;
		logic [NRM_BITS:0] ka;
	} nrm_t;

	// unsaturated new centres and flags out of the impulse pipe
	typedef struct packed {
		logic signed [RW-1:0] ax;
		logic signed [RW-1:0] ay;
		logic signed [RW-1:0] bx;
		logic signed [RW-1:0] by;
		logic                 touching;
		logic                 degenerate;
	} imp_t;

	// round(a*b / 2^sh), halves away from zero
	function automatic logic signed [RW-1:0] smul_rnd(input logic signed [MA_W-1:0] a,
			input logic signed [MB_W-1:0] b, input logic [5:0] sh);
		logic [MA_W-1:0]      am;
		logic [MB_W-1:0]      bm;
		logic [MA_W+MB_W-1:0] p;
		logic [MA_W+MB_W-1:0] r;
		am = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
		bm = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
		p  = {{MB_W{1'b0}}, am} * {{MA_W{1'b0}}, bm};
		r  = (p + ((MA_W+MB_W)'(1) << (sh - 6'd1))) >> sh;
		return (a[MA_W-1] ^ b[MB_W-1]) ? -RW'(r) : RW'(r);
	endfunction

endpackage

>>> rtl/cec_sqrt.sv
// Pipelined integer square root, one root bit per stage
module cec_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  cec_pkg::pair_t   in_pair,
	input  logic [cec_pkg::SQW-1:0] rad,
	output logic             out_valid,
	output cec_pkg::pair_t   out_pair,
	output logic [cec_pkg::DW-1:0]  root
);
	import cec_pkg::*;

	logic [SQW-1:0] rem_s  [0:SQ_STEPS-1];
	logic [SQW-1:0] root_s [0:SQ_STEPS-1];
	pair_t          pair_s [0:SQ_STEPS-1];
	logic           vld_s  [0:SQ_STEPS-1];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
		localparam logic [SQW-1:0] ONE = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [SQW-1:0] rem_i;
		logic [SQW-1:0] root_i;
		logic [SQW-1:0] trial;
		pair_t          pair_i;
		logic           vld_i;

		if (k == 0) begin : g_first
			assign rem_i  = rad;
			assign root_i = '0;
			assign pair_i = in_pair;
			assign vld_i  = in_valid;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign pair_i = pair_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign trial = root_i + ONE;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pair_s[k] <= pair_i;
				if (rem_i >= trial) begin
					rem_s[k]  <= rem_i - trial;
					root_s[k] <= (root_i >> 1) + ONE;
				end else begin
					rem_s[k]  <= rem_i;
					root_s[k] <= root_i >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS-1];
	assign out_pair  = pair_s[SQ_STEPS-1];
	assign root      = root_s[SQ_STEPS-1][DW-1:0];

endmodule

>>> rtl/cec_div.sv
// Pipelined Q.30 fraction divider, three lanes: normal x, normal y, mass split
module cec_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  cec_pkg::pair_t         in_pair,
	input  logic [cec_pkg::DW-1:0] in_dist,
	output logic                   out_valid,
	output cec_pkg::pair_t         out_pair,
	output logic [cec_pkg::DW-1:0] out_dist,
	output cec_pkg::nrm_t          nrm
);
	import cec_pkg::*;

	localparam int NL   = 3;
	localparam int LN_X = 0;
	localparam int LN_Y = 1;
	localparam int LN_K = 2;

	logic [DW-1:0]       r_s    [0:NRM_BITS][0:NL-1];
	logic [DW-1:0]       den_s  [0:NRM_BITS][0:NL-1];
	logic [NRM_BITS-1:0] q_s    [0:NRM_BITS][0:NL-1];
	logic                done_s [0:NRM_BITS][0:NL-1];
	logic                mz_s   [0:NRM_BITS];
	logic [DW-1:0]       dist_s [0:NRM_BITS];
	pair_t               pair_s [0:NRM_BITS];
	logic                vld_s  [0:NRM_BITS];

	// entry stage: operands, and the quotient-is-one case
	logic signed [PW:0] dx;
	logic signed [PW:0] dy;
	logic [DW-1:0]      num_c [0:NL-1];
	logic [DW-1:0]      den_c [0:NL-1];

	assign dx = (PW+1)'(in_pair.a_pos_x) - (PW+1)'(in_pair.b_pos_x);
	assign dy = (PW+1)'(in_pair.a_pos_y) - (PW+1)'(in_pair.b_pos_y);

	always_comb begin
		num_c[LN_X] = dx[PW] ? DW'(-dx) : DW'(dx);
		num_c[LN_Y] = dy[PW] ? DW'(-dy) : DW'(dy);
		num_c[LN_K] = DW'(in_pair.b_mass);
		den_c[LN_X] = in_dist;
		den_c[LN_Y] = in_dist;
		den_c[LN_K] = DW'(in_pair.a_mass) + DW'(in_pair.b_mass);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s[0] <= in_pair;
			dist_s[0] <= in_dist;
			mz_s[0]   <= (den_c[LN_K] == '0);
			for (int l = 0; l < NL; l++) begin
				r_s[0][l]    <= num_c[l];
				den_s[0][l]  <= den_c[l];
				q_s[0][l]    <= '0;
				done_s[0][l] <= (num_c[l] >= den_c[l]);
			end
		end
	end

	// restoring steps, one quotient bit per stage
	for (genvar k = 1; k <= NRM_BITS; k++) begin : g_step
		logic [DW:0] r2 [0:NL-1];
		logic        ge [0:NL-1];

		always_comb begin
			for (int l = 0; l < NL; l++) begin
				r2[l] = {r_s[k-1][l], 1'b0};
				ge[l] = (r2[l] >= {1'b0, den_s[k-1][l]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pair_s[k] <= pair_s[k-1];
				dist_s[k] <= dist_s[k-1];
				mz_s[k]   <= mz_s[k-1];
				for (int l = 0; l < NL; l++) begin
					r_s[k][l]    <= ge[l] ? DW'(r2[l] - {1'b0, den_s[k-1][l]}) : r2[l][DW-1:0];
					q_s[k][l]    <= {q_s[k-1][l][NRM_BITS-2:0], ge[l]};
					den_s[k][l]  <= den_s[k-1][l];
					done_s[k][l] <= done_s[k-1][l];
				end
			end
		end
	end

	// round to nearest
	logic [NRM_BITS:0] qr_c [0:NL-1];
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			if (done_s[NRM_BITS][l]) begin
				qr_c[l] = (NRM_BITS+1)'(1) << NRM_BITS;
			end else begin
				qr_c[l] = (NRM_BITS+1)'(q_s[NRM_BITS][l])
					+ (NRM_BITS+1)'({r_s[NRM_BITS][l], 1'b0} >= {1'b0, den_s[NRM_BITS][l]});
			end
		end
	end

	logic  vld_sr;
	pair_t pair_sr;
	logic [DW-1:0] dist_sr;
	nrm_t  nrm_sr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sr <= 1'b0;
		end else if (en) begin
			vld_sr <= vld_s[NRM_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_sr       <= pair_s[NRM_BITS];
			dist_sr       <= dist_s[NRM_BITS];
			nrm_sr.nx_mag <= qr_c[LN_X];
			nrm_sr.ny_mag <= qr_c[LN_Y];
			// both masses zero: even split
			nrm_sr.ka     <= mz_s[NRM_BITS] ? (NRM_BITS+1)'(1) << (NRM_BITS - 1) : qr_c[LN_K];
		end
	end

	assign out_valid = vld_sr;
	assign out_pair  = pair_sr;
	assign out_dist  = dist_sr;
	assign nrm       = nrm_sr;

endmodule

>>> rtl/cec_impulse.sv
// Impulse and separation datapath: seven multiply and add stages
module cec_impulse (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [15:0]            restitution,
	input  logic                   in_valid,
	input  cec_pkg::pair_t         in_pair,
	input  logic [cec_pkg::DW-1:0] in_dist,
	input  cec_pkg::nrm_t          nrm,
	output logic                   out_valid,
	output cec_pkg::pair_t         out_pair,
	output cec_pkg::imp_t          imp
);
	import cec_pkg::*;

	localparam logic [5:0] SH_N  = 6'(NRM_BITS);
	localparam logic [5:0] SH_H  = 6'(NRM_BITS + 1);
	localparam logic [5:0] SH_E  = 6'd14;

	logic [6:0] vld_q;
	pair_t pair_s1, pair_s2, pair_s3, pair_s4, pair_s5, pair_s6, pair_s7;

	// stage 1: signed normal, relative velocity, overlap, contact test
	logic [PW-1:0]       rsum;
	logic                dx_neg, dy_neg, dzero;
	logic signed [MB_W-1:0] nx_s1, ny_s1;
	logic [NRM_BITS:0]   ka_s1, kb_s1;
	logic signed [PW+1:0] rvx_s1, rvy_s1, ov_s1;
	logic                touch_s1, degen_s1;

	assign rsum   = PW'(in_pair.a_radius) + PW'(in_pair.b_radius);
	assign dx_neg = in_pair.a_pos_x < in_pair.b_pos_x;
	assign dy_neg = in_pair.a_pos_y < in_pair.b_pos_y;
	assign dzero  = (in_dist == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1 <= in_pair;
			nx_s1 <= dzero ? '0 : (dx_neg ? -$signed({1'b0, nrm.nx_mag}) : $signed({1'b0, nrm.nx_mag}));
			ny_s1 <= dzero ? '0 : (dy_neg ? -$signed({1'b0, nrm.ny_mag}) : $signed({1'b0, nrm.ny_mag}));
			ka_s1 <= nrm.ka;
			kb_s1 <= ((NRM_BITS+1)'(1) << NRM_BITS) - nrm.ka;
			rvx_s1 <= (PW+2)'(in_pair.a_pos_x) - (PW+2)'(in_pair.a_prev_x)
				- (PW+2)'(in_pair.b_pos_x) + (PW+2)'(in_pair.b_prev_x);
			rvy_s1 <= (PW+2)'(in_pair.a_pos_y) - (PW+2)'(in_pair.a_prev_y)
				- (PW+2)'(in_pair.b_pos_y) + (PW+2)'(in_pair.b_prev_y);
			ov_s1 <= $signed((PW+2)'(rsum)) - $signed((PW+2)'(in_dist));
			touch_s1 <= (in_dist <= DW'(rsum));
			degen_s1 <= (in_dist <= DW'(rsum)) && dzero;
		end
	end

	// stage 2: velocity and overlap onto the normal
	logic signed [RW-1:0] px_s2, py_s2, sx_s2, sy_s2;
	logic signed [MB_W-1:0] nx_s2, ny_s2;
	logic [NRM_BITS:0] ka_s2, kb_s2;
	logic touch_s2, degen_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2 <= pair_s1;
			px_s2 <= smul_rnd(MA_W'(rvx_s1), nx_s1, SH_N);
			py_s2 <= smul_rnd(MA_W'(rvy_s1), ny_s1, SH_N);
			sx_s2 <= smul_rnd(MA_W'(ov_s1), nx_s1, SH_H);
			sy_s2 <= smul_rnd(MA_W'(ov_s1), ny_s1, SH_H);
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			ka_s2 <= ka_s1;
			kb_s2 <= kb_s1;
			touch_s2 <= touch_s1;
			degen_s2 <= degen_s1;
		end
	end

	// stage 3: dot product
	logic signed [RW-1:0] dot_s3, sx_s3, sy_s3;
	logic signed [MB_W-1:0] nx_s3, ny_s3;
	logic [NRM_BITS:0] ka_s3, kb_s3;
	logic touch_s3, degen_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s3 <= pair_s2;
			dot_s3 <= px_s2 + py_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			ka_s3 <= ka_s2;
			kb_s3 <= kb_s2;
			touch_s3 <= touch_s2;
			degen_s3 <= degen_s2;
		end
	end

	// stage 4: scale by (1 + e)
	logic [16:0] e1;
	logic signed [RW-1:0] t_s4, sx_s4, sy_s4;
	logic signed [MB_W-1:0] nx_s4, ny_s4;
	logic [NRM_BITS:0] ka_s4, kb_s4;
	logic touch_s4, degen_s4;

	assign e1 = RST_ONE + 17'(restitution);

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s4 <= pair_s3;
			t_s4 <= smul_rnd(MA_W'(dot_s3), $signed({15'b0, e1}), SH_E);
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
			nx_s4 <= nx_s3;
			ny_s4 <= ny_s3;
			ka_s4 <= ka_s3;
			kb_s4 <= kb_s3;
			touch_s4 <= touch_s3;
			degen_s4 <= degen_s3;
		end
	end

	// stage 5: impulse share per circle
	logic signed [RW-1:0] ga_s5, gb_s5, sx_s5, sy_s5;
	logic signed [MB_W-1:0] nx_s5, ny_s5;
	logic touch_s5, degen_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s5 <= pair_s4;
			ga_s5 <= -smul_rnd(MA_W'(t_s4), $signed({1'b0, ka_s4}), SH_N);
			gb_s5 <= smul_rnd(MA_W'(t_s4), $signed({1'b0, kb_s4}), SH_N);
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
			nx_s5 <= nx_s4;
			ny_s5 <= ny_s4;
			touch_s5 <= touch_s4;
			degen_s5 <= degen_s4;
		end
	end

	// stage 6: impulse along the normal
	logic signed [RW-1:0] iax_s6, iay_s6, ibx_s6, iby_s6, sx_s6, sy_s6;
	logic touch_s6, degen_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s6 <= pair_s5;
			iax_s6 <= smul_rnd(MA_W'(ga_s5), nx_s5, SH_N);
			iay_s6 <= smul_rnd(MA_W'(ga_s5), ny_s5, SH_N);
			ibx_s6 <= smul_rnd(MA_W'(gb_s5), nx_s5, SH_N);
			iby_s6 <= smul_rnd(MA_W'(gb_s5), ny_s5, SH_N);
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
			touch_s6 <= touch_s5;
			degen_s6 <= degen_s5;
		end
	end

	// stage 7: pos + v + impulse +/- half overlap
	imp_t imp_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s7 <= pair_s6;
			imp_s7.ax <= RW'(pair_s6.a_pos_x) + RW'(pair_s6.a_pos_x) - RW'(pair_s6.a_prev_x)
				+ iax_s6 + sx_s6;
			imp_s7.ay <= RW'(pair_s6.a_pos_y) + RW'(pair_s6.a_pos_y) - RW'(pair_s6.a_prev_y)
				+ iay_s6 + sy_s6;
			imp_s7.bx <= RW'(pair_s6.b_pos_x) + RW'(pair_s6.b_pos_x) - RW'(pair_s6.b_prev_x)
				+ ibx_s6 - sx_s6;
			imp_s7.by <= RW'(pair_s6.b_pos_y) + RW'(pair_s6.b_pos_y) - RW'(pair_s6.b_prev_y)
				+ iby_s6 - sy_s6;
			imp_s7.touching   <= touch_s6;
			imp_s7.degenerate <= degen_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], in_valid};
		end
	end

	assign out_valid = vld_q[6];
	assign out_pair  = pair_s7;
	assign imp       = imp_s7;

endmodule

>>> rtl/circle_elastic_collision.sv
// Top level: circle pair collision response, fully pipelined
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------
//  pair     | pair_valid / pair_stall        | pair   (cec_pkg::pair_t)
//  result   | result_valid / result_stall    | result (cec_pkg::result_t)
//  config   | cfg_wr_en                      | cfg_wr_data (restitution)
//
// One pair per cycle unless a held result stalls the pipeline; stages: 3 front, 33 sqrt, 32 divide, 7 impulse, 1 out.
// Depth is set by the bit-serial square root and the 30-step Q.30 divider.
// Reset clears all valid bits and loads restitution with 13107.
// A held result freezes the whole pipeline; pair_stall follows result_stall then.
`include "circle_elastic_collision_defines.svh"

module circle_elastic_collision (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pair_valid,
	output logic             pair_stall,
	input  cec_pkg::pair_t   pair,
	output logic             result_valid,
	input  logic             result_stall,
	output cec_pkg::result_t result,
	input  logic             cfg_wr_en,
	input  logic [15:0]      cfg_wr_data
);
	import cec_pkg::*;

	logic [15:0] restitution_q;
	logic        pipe_en;
	logic        out_valid_q;
	result_t     result_q;

	assign pipe_en    = !(out_valid_q && result_stall);
	assign pair_stall = !pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= RST_RESET;
		end else if (cfg_wr_en) begin
			restitution_q <= cfg_wr_data;
		end
	end

	// front end: |dx|, |dy|, squares, radicand
	logic signed [PW:0] dx, dy;
	logic [DW-1:0]      dxm_s1, dym_s1;
	logic [2*DW-1:0]    sqx_s2, sqy_s2;
	logic [SQW-1:0]     rad_s3;
	pair_t              pair_s1, pair_s2, pair_s3;
	logic [2:0]         fv_q;

	assign dx = (PW+1)'(pair.a_pos_x) - (PW+1)'(pair.b_pos_x);
	assign dy = (PW+1)'(pair.a_pos_y) - (PW+1)'(pair.b_pos_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
		end else if (pipe_en) begin
			fv_q <= {fv_q[1:0], pair_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			pair_s1 <= pair;
			dxm_s1  <= dx[PW] ? DW'(-dx) : DW'(dx);
			dym_s1  <= dy[PW] ? DW'(-dy) : DW'(dy);
			pair_s2 <= pair_s1;
			sqx_s2  <= {{DW{1'b0}}, dxm_s1} * {{DW{1'b0}}, dxm_s1};
			sqy_s2  <= {{DW{1'b0}}, dym_s1} * {{DW{1'b0}}, dym_s1};
			pair_s3 <= pair_s2;
			rad_s3  <= SQW'(sqx_s2) + SQW'(sqy_s2);
		end
	end

	logic          sq_valid;
	pair_t         sq_pair;
	logic [DW-1:0] sq_dist;

	cec_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (fv_q[2]),
		.in_pair  (pair_s3),
		.rad      (rad_s3),
		.out_valid(sq_valid),
		.out_pair (sq_pair),
		.root     (sq_dist)
	);

	logic          dv_valid;
	pair_t         dv_pair;
	logic [DW-1:0] dv_dist;
	nrm_t          dv_nrm;

	cec_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_valid (sq_valid),
		.in_pair  (sq_pair),
		.in_dist  (sq_dist),
		.out_valid(dv_valid),
		.out_pair (dv_pair),
		.out_dist (dv_dist),
		.nrm      (dv_nrm)
	);

	logic  imp_valid;
	pair_t imp_pair;
	imp_t  imp;

	cec_impulse u_impulse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (pipe_en),
		.restitution(restitution_q),
		.in_valid   (dv_valid),
		.in_pair    (dv_pair),
		.in_dist    (dv_dist),
		.nrm        (dv_nrm),
		.out_valid  (imp_valid),
		.out_pair   (imp_pair),
		.imp        (imp)
	);

	function automatic logic signed [PW-1:0] sat(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] hi;
		logic signed [RW-1:0] lo;
		hi = RW'({1'b0, {(PW-1){1'b1}}});
		lo = -hi - RW'(1);
		if (v > hi) begin
			return PW'(hi);
		end else if (v < lo) begin
			return PW'(lo);
		end
		return PW'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pipe_en) begin
			out_valid_q <= imp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			if (imp.touching) begin
				result_q.a_new_x      <= sat(imp.ax);
				result_q.a_new_y      <= sat(imp.ay);
				result_q.b_new_x      <= sat(imp.bx);
				result_q.b_new_y      <= sat(imp.by);
				result_q.a_new_prev_x <= imp_pair.a_pos_x;
				result_q.a_new_prev_y <= imp_pair.a_pos_y;
				result_q.b_new_prev_x <= imp_pair.b_pos_x;
				result_q.b_new_prev_y <= imp_pair.b_pos_y;
			end else begin
				result_q.a_new_x      <= imp_pair.a_pos_x;
				result_q.a_new_y      <= imp_pair.a_pos_y;
				result_q.b_new_x      <= imp_pair.b_pos_x;
				result_q.b_new_y      <= imp_pair.b_pos_y;
				result_q.a_new_prev_x <= imp_pair.a_prev_x;
				result_q.a_new_prev_y <= imp_pair.a_prev_y;
				result_q.b_new_prev_x <= imp_pair.b_prev_x;
				result_q.b_new_prev_y <= imp_pair.b_prev_y;
			end
			result_q.touching   <= imp.touching;
			result_q.degenerate <= imp.degenerate;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

	`CEC_ASSERT_IMP(a_degen_touch, out_valid_q && result_q.degenerate, result_q.touching, "degenerate without touching")
	`CEC_ASSERT_IMP(a_stall_back, out_valid_q && result_stall, pair_stall, "held result did not stall input")
	`CEC_ASSERT_NXT(a_imp_hold, imp_valid && pair_stall, imp_valid, "pipeline lost a transaction under stall")
	`CEC_ASSERT_IMP(a_rise_adv, $rose(out_valid_q), $past(pipe_en), "result appeared without pipeline advance")

endmodule

>>> tb/circle_elastic_collision_tb.sv
// Self-checking testbench for the circle pair collision response block
module circle_elastic_collision_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cec_pkg::*;

	localparam int LATENCY = 76;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pair_valid = 1'b0;
	logic        pair_stall;
	pair_t       pair = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	pair_t   pending_pairs[$];
	result_t expected_results[$];
	logic [15:0] restitution_q = RST_RESET;
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  error_count = 0;

	circle_elastic_collision i_dut (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// round(a*b / 2^sh), halves away from zero
	function automatic longint round_mul(longint a, longint b, int sh);
		logic [127:0] p;
		longint am, bm;
		am = a < 0 ? -a : a;
		bm = b < 0 ? -b : b;
		p = {64'd0, am} * {64'd0, bm};
		p = (p + (128'd1 << (sh - 1))) >> sh;
		return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	// round(num * 2^30 / den), clamped to 1.0
	function automatic longint frac_q30(logic [63:0] num, logic [63:0] den);
		logic [63:0] q, r;
		q = 0;
		r = num;
		if (r >= den)
			return longint'(64'd1 << NRM_BITS);
		for (int i = 0; i < NRM_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		if (2 * r >= den)
			q++;
		return longint'(q);
	endfunction

	function automatic longint signed_frac_q30(longint v, logic [63:0] den);
		longint q;
		q = frac_q30(v < 0 ? -v : v, den);
		return v < 0 ? -q : q;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic result_t predict_collision(pair_t p);
		result_t r;
		longint ax, ay, pax, pay, bx, by, pbx, pby, vax, vay, vbx, vby, dx, dy;
		longint nx, ny, dotp, t, ga, gb, ov, sx, sy, ka, kb;
		logic [127:0] radicand, sq;
		logic [63:0] d, dt, sum, msum;
		ax = $signed(p.a_pos_x);  ay = $signed(p.a_pos_y);
		pax = $signed(p.a_prev_x); pay = $signed(p.a_prev_y);
		bx = $signed(p.b_pos_x);  by = $signed(p.b_pos_y);
		pbx = $signed(p.b_prev_x); pby = $signed(p.b_prev_y);
		vax = ax - pax; vay = ay - pay; vbx = bx - pbx; vby = by - pby;
		dx = ax - bx; dy = ay - by;
		sum = 64'(p.a_radius) + 64'(p.b_radius);
		radicand = {64'd0, 64'(dx < 0 ? -dx : dx)} * {64'd0, 64'(dx < 0 ? -dx : dx)}
			+ {64'd0, 64'(dy < 0 ? -dy : dy)} * {64'd0, 64'(dy < 0 ? -dy : dy)};
		d = 0;
		for (int b = 49; b >= 0; b--) begin
			dt = d | (64'd1 << b);
			sq = {64'd0, dt} * {64'd0, dt};
			if (sq <= radicand)
				d = dt;
		end
		r = '0;
		if (d > sum) begin
			r.a_new_x = p.a_pos_x;     r.a_new_y = p.a_pos_y;
			r.a_new_prev_x = p.a_prev_x; r.a_new_prev_y = p.a_prev_y;
			r.b_new_x = p.b_pos_x;     r.b_new_y = p.b_pos_y;
			r.b_new_prev_x = p.b_prev_x; r.b_new_prev_y = p.b_prev_y;
			return r;
		end
		nx = 0;
		ny = 0;
		if (d != 0) begin
			nx = signed_frac_q30(dx, d);
			ny = signed_frac_q30(dy, d);
		end
		dotp = round_mul(vax - vbx, nx, NRM_BITS) + round_mul(vay - vby, ny, NRM_BITS);
		msum = 64'(p.a_mass) + 64'(p.b_mass);
		ka = (msum == 0) ? longint'(64'd1 << (NRM_BITS - 1)) : frac_q30(64'(p.b_mass), msum);
		kb = longint'(64'd1 << NRM_BITS) - ka;
		t = round_mul(longint'(RST_ONE) + longint'(restitution_q), dotp, 14);
		ga = -round_mul(t, ka, NRM_BITS);
		gb = round_mul(t, kb, NRM_BITS);
		ov = longint'(sum - d);
		sx = round_mul(ov, nx, NRM_BITS + 1);
		sy = round_mul(ov, ny, NRM_BITS + 1);
		r.a_new_x = clamp32(ax + vax + round_mul(ga, nx, NRM_BITS) + sx);
		r.a_new_y = clamp32(ay + vay + round_mul(ga, ny, NRM_BITS) + sy);
		r.b_new_x = clamp32(bx + vbx + round_mul(gb, nx, NRM_BITS) - sx);
		r.b_new_y = clamp32(by + vby + round_mul(gb, ny, NRM_BITS) - sy);
		r.a_new_prev_x = p.a_pos_x; r.a_new_prev_y = p.a_pos_y;
		r.b_new_prev_x = p.b_pos_x; r.b_new_prev_y = p.b_pos_y;
		r.touching = 1'b1;
		r.degenerate = (d == 0);
		return r;
	endfunction

	function automatic logic [30:0] rand_mass();
		case ($urandom_range(19))
			0: return '0;
			1, 2, 3, 4: return 31'($urandom);
			5, 6: return 31'd65536;
			default: return 31'($urandom_range(1 << 20, 1));
		endcase
	endfunction

	// mostly near pairs at a random scale so the collision path is exercised
	function automatic pair_t rand_pair();
		pair_t p;
		int k, span;
		logic signed [31:0] bx, by;
		if ($urandom_range(99) < 15) begin
			p.a_pos_x  = $urandom;
			p.a_pos_y  = $urandom;
			p.a_prev_x = $urandom;
			p.a_prev_y = $urandom;
			p.a_radius = 31'($urandom);
			p.a_mass   = 31'($urandom);
			p.b_pos_x  = $urandom;
			p.b_pos_y  = $urandom;
			p.b_prev_x = $urandom;
			p.b_prev_y = $urandom;
			p.b_radius = 31'($urandom);
			p.b_mass   = 31'($urandom);
			return p;
		end
		k = $urandom_range(24, 1);
		span = 1 << k;
		bx = $signed($urandom) >>> $urandom_range(12, 0);
		by = $signed($urandom) >>> $urandom_range(12, 0);
		p.b_pos_x = bx;
		p.b_pos_y = by;
		p.a_pos_x = bx + $signed(32'($urandom_range(2 * span))) - span;
		p.a_pos_y = by + $signed(32'($urandom_range(2 * span))) - span;
		if ($urandom_range(29) == 0)
			p.a_pos_y = by;
		if ($urandom_range(29) == 0) begin
			p.a_pos_x = bx;
			p.a_pos_y = by;
		end
		p.a_radius = 31'($urandom_range(span));
		p.b_radius = 31'($urandom_range(span));
		p.a_prev_x = p.a_pos_x - $signed(32'($urandom_range(span))) + (span >> 1);
		p.a_prev_y = p.a_pos_y - $signed(32'($urandom_range(span))) + (span >> 1);
		p.b_prev_x = p.b_pos_x - $signed(32'($urandom_range(span))) + (span >> 1);
		p.b_prev_y = p.b_pos_y - $signed(32'($urandom_range(span))) + (span >> 1);
		p.a_mass = rand_mass();
		p.b_mass = rand_mass();
		return p;
	endfunction

	function automatic pair_t make_pair(int ax, int ay, int pax, int pay, int ra, int ma,
			int bx, int by, int pbx, int pby, int rb, int mb);
		pair_t p;
		p = {ax, ay, pax, pay, 31'(ra), 31'(ma), bx, by, pbx, pby, 31'(rb), 31'(mb)};
		return p;
	endfunction

	// sender: holds the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid <= 1'b0;
		end else begin
			if (pair_valid && !pair_stall) begin
				expected_results.push_back(predict_collision(pair));
				void'(pending_pairs.pop_front());
			end
			if (!(pair_valid && pair_stall)) begin
				if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					pair_valid <= 1'b1;
					pair <= pending_pairs[0];
				end else begin
					pair_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s expected %0d actual %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	// receiver and checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					error_count++;
				end else begin
					e = expected_results.pop_front();
					check_field("a_new_x", e.a_new_x, result.a_new_x);
					check_field("a_new_y", e.a_new_y, result.a_new_y);
					check_field("a_new_prev_x", e.a_new_prev_x, result.a_new_prev_x);
					check_field("a_new_prev_y", e.a_new_prev_y, result.a_new_prev_y);
					check_field("b_new_x", e.b_new_x, result.b_new_x);
					check_field("b_new_y", e.b_new_y, result.b_new_y);
					check_field("b_new_prev_x", e.b_new_prev_x, result.b_new_prev_x);
					check_field("b_new_prev_y", e.b_new_prev_y, result.b_new_prev_y);
					check_field("touching", e.touching, result.touching);
					check_field("degenerate", e.degenerate, result.degenerate);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic drain();
		do @(negedge clk); while (pending_pairs.size() != 0 || expected_results.size() != 0);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	task automatic write_restitution(logic [15:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		restitution_q = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [15:0] rst_vals[5];
		int idle_vals[5], stall_vals[5];
		rst_vals = '{16'd13107, 16'd0, 16'd32768, 16'hffff, 16'd16384};
		idle_vals = '{0, 46, 0, 37, 0};
		stall_vals = '{0, 0, 46, 37, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: apart, coincident, zero masses, saturation, field extremes
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 10, 65536, 1000, 0, 1000, 0, 10, 65536));
		pending_pairs.push_back(make_pair(5, 7, 3, 2, 100, 65536, 5, 7, 9, 1, 100, 65536));
		pending_pairs.push_back(make_pair(5, 7, 3, 2, 0, 65536, 5, 7, 9, 1, 0, 65536));
		pending_pairs.push_back(make_pair(0, 0, -500, 0, 600, 0, 1000, 0, 1500, 0, 600, 65536));
		pending_pairs.push_back(make_pair(0, 0, -500, 0, 600, 65536, 1000, 0, 1500, 0, 600, 0));
		pending_pairs.push_back(make_pair(0, 10, -500, 0, 600, 0, 1000, 0, 1500, 3, 600, 0));
		pending_pairs.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7ffffff0, 32'h7ffffff0,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 1, 32'h80000010, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7fffffff, 1));
		pending_pairs.push_back(make_pair(32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
		pending_pairs.push_back(make_pair(32'h7fffffff, 32'h80000000, 0, 0, 0, 1,
			32'h80000000, 32'h7fffffff, 0, 0, 0, 1));
		pending_pairs.push_back(make_pair(-1, -1, -1, -1, 32'h7fffffff, 32'h7fffffff,
			-1, -1, -1, -1, 32'h7fffffff, 32'h7fffffff));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
		pending_pairs.push_back(make_pair(300, 400, 0, 0, 250, 65536, 0, 0, 300, 400, 250,
			131072));
		pending_pairs.push_back(make_pair(300, 400, 0, 0, 250, 65536, 0, 0, 300, 400, 249,
			131072));
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			write_restitution(ph == 4 ? 16'($urandom) : rst_vals[ph]);
			send_idle_pct = idle_vals[ph];
			recv_stall_pct = stall_vals[ph];
			for (int i = 0; i < 100; i++)
				pending_pairs.push_back(rand_pair());
			// sender holds off until the pipeline has emptied
			drain();
		end
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("status: fail");
		$finish;
	end

endmodule
